[hw/rtl/cbm_pkg.sv]
`default_nettype none

package cbm_pkg;

  // Bank counts of the cartridge; both are powers of two
  localparam int unsigned ROM_BANKS = 128;
  localparam int unsigned RAM_BANKS = 8;

  // Field widths
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned MemAddrW = 21;
  localparam int unsigned RomBankW = 7;
  localparam int unsigned RamSelW  = 4;
  localparam int unsigned RamBankW = 3;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Bank wrap masks (modulo by a power-of-two bank count)
  localparam logic [RomBankW-1:0] RomBankMask = RomBankW'(ROM_BANKS - 1);
  localparam logic [RamBankW-1:0] RamBankMask = RamBankW'(RAM_BANKS - 1);

  // External RAM window
  localparam int unsigned RamWinBytes = 8192;
  localparam int unsigned PageBytes   = 256;
  localparam logic [5:0]  WinPagesMax = 6'(RamWinBytes / PageBytes);

  // RAM/RTC select codes
  localparam logic [DataW-1:0]   RamSelMax = 8'h0C;
  localparam logic [RamSelW-1:0] RtcSelMin = 4'h8;

  // Constant read data
  localparam logic [DataW-1:0] OpenBusData = 8'hFF;
  localparam logic [DataW-1:0] RtcStubData = 8'h00;

  // Register reset values
  localparam logic [RomBankW-1:0] RomBankMaskRst = 7'h7F;
  localparam logic [SizeW-1:0]    RamSizeRst     = 16'd8192;
  localparam logic [RomBankW-1:0] RomBankRst     = 7'd1;
  localparam logic [RamSelW-1:0]  RamSelRst      = 4'd0;

  // Access kind
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRomBankMask = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRamSize     = 1'd1;

  typedef enum logic [1:0] {
    TgtNone  = 2'd0,
    TgtRom   = 2'd1,
    TgtRam   = 2'd2,
    TgtConst = 2'd3
  } cbm_target_e;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } cbm_req_t;

  typedef struct packed {
    cbm_target_e         target;
    logic [MemAddrW-1:0] mem_address;
    logic                mem_write;
    logic [DataW-1:0]    mem_data;
  } cbm_rsp_t;

  typedef struct packed {
    logic [RomBankW-1:0] rom_bank_mask;
    logic [SizeW-1:0]    ram_size;
  } cbm_cfg_t;

  // Handshake between the input register and the rest of the pipe
  typedef struct packed {
    logic     valid;
    cbm_req_t req;
  } cbm_stage_t;

endpackage

`default_nettype wire

[hw/rtl/cbm_if.sv]
`default_nettype none

interface cbm_req_if import cbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

interface cbm_rsp_if import cbm_pkg::*; ();
  logic                valid;
  logic                ready;
  cbm_target_e         target;
  logic [MemAddrW-1:0] mem_address;
  logic                mem_write;
  logic [DataW-1:0]    mem_data;

  modport source (output valid, output target, output mem_address, output mem_write,
                  output mem_data, input ready);
  modport sink   (input valid, input target, input mem_address, input mem_write,
                  input mem_data, output ready);
endinterface

`default_nettype wire

[hw/rtl/cbm_in_reg.sv]
`default_nettype none

module cbm_in_reg import cbm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cbm_req_if.sink     req_i,
  input  wire logic   advance_i,
  output cbm_stage_t  stage_o
);

  logic     valid_q, valid_d;
  cbm_req_t req_q;
  logic     load;

  // Take a new beat when empty or when the held one moves on
  assign req_i.ready = !valid_q || advance_i;
  assign load        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload of the accepted beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.op         <= req_i.op;
      req_q.address    <= req_i.address;
      req_q.write_data <= req_i.write_data;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.req   = req_q;

endmodule

`default_nettype wire

[hw/rtl/cbm_translate.sv]
`default_nettype none

module cbm_translate import cbm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cbm_stage_t stage_i,
  input  wire logic       fire_i,
  input  wire cbm_cfg_t   cfg_i,
  output cbm_rsp_t        rsp_o
);

  logic [RomBankW-1:0] rom_bank_q, rom_bank_d;
  logic [RamSelW-1:0]  ram_select_q, ram_select_d;

  logic [AddrW-1:0]    addr;
  logic [DataW-1:0]    data;
  logic                wr;
  logic [RomBankW-1:0] rom_sel;
  logic [RamBankW-1:0] ram_bank;
  logic [5:0]          win_pages;
  logic                in_window;

  assign addr = stage_i.req.address;
  assign data = stage_i.req.write_data;
  assign wr   = (stage_i.req.op == OpWrite);

  // Pick the ROM bank for the switchable window; bank zero reads as bank one
  always_comb begin
    if (!addr[14]) begin
      rom_sel = '0;
    end else if (rom_bank_q == '0) begin
      rom_sel = RomBankW'(1);
    end else begin
      rom_sel = rom_bank_q & cfg_i.rom_bank_mask & RomBankMask;
    end
  end

  // Size the RAM window in pages, capped at one bank
  assign win_pages = (cfg_i.ram_size > SizeW'(RamWinBytes)) ? WinPagesMax
                                                           : cfg_i.ram_size[13:8];
  assign in_window = ({1'b0, addr[12:8]} < win_pages);
  assign ram_bank  = ram_select_q[RamBankW-1:0] & RamBankMask;

  // Translate the held access and work out the next bank state
  always_comb begin
    rsp_o.target      = TgtNone;
    rsp_o.mem_address = '0;
    rsp_o.mem_write   = 1'b0;
    rsp_o.mem_data    = '0;
    rom_bank_d        = rom_bank_q;
    ram_select_d      = ram_select_q;
    if (!addr[15]) begin
      if (!wr) begin
        rsp_o.target      = TgtRom;
        rsp_o.mem_address = {rom_sel, addr[13:0]};
      end else if (addr[15:13] == 3'b001) begin
        rom_bank_d = data[RomBankW-1:0];
      end else if (addr[15:13] == 3'b010) begin
        if (data <= RamSelMax) begin
          ram_select_d = data[RamSelW-1:0];
        end
      end
    end else if (addr[15:13] == 3'b101) begin
      if (ram_select_q >= RtcSelMin) begin
        if (!wr) begin
          rsp_o.target   = TgtConst;
          rsp_o.mem_data = RtcStubData;
        end
      end else if (in_window) begin
        rsp_o.target      = TgtRam;
        rsp_o.mem_address = {5'd0, ram_bank, addr[12:0]};
        rsp_o.mem_write   = wr;
        rsp_o.mem_data    = wr ? data : '0;
      end else if (!wr) begin
        rsp_o.target   = TgtConst;
        rsp_o.mem_data = OpenBusData;
      end
    end
  end

  // Commit bank state when the beat moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q   <= RomBankRst;
      ram_select_q <= RamSelRst;
    end else if (fire_i) begin
      rom_bank_q   <= rom_bank_d;
      ram_select_q <= ram_select_d;
    end
  end

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_select_q <= RamSelMax[RamSelW-1:0])
    else $error("ram select holds an undefined code");

  a_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && stage_i.valid && wr && addr[15:13] == 3'b001)
    |=> rom_bank_q == $past(data[RomBankW-1:0]))
    else $error("rom bank write not committed");

  a_wr_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.mem_write |-> rsp_o.target == TgtRam)
    else $error("memory write outside external RAM");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.target == TgtNone || rsp_o.target == TgtConst) |-> rsp_o.mem_address == '0)
    else $error("address driven without memory access");

endmodule

`default_nettype wire

[hw/rtl/cbm_out_reg.sv]
`default_nettype none

module cbm_out_reg import cbm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cbm_rsp_t rsp_i,
  input  wire logic     load_i,
  output logic          free_o,
  cbm_rsp_if.source     rsp_o
);

  logic     valid_q, valid_d;
  cbm_rsp_t rsp_q;

  // Room when empty or when the held beat is taken this cycle
  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.target      = rsp_q.target;
  assign rsp_o.mem_address = rsp_q.mem_address;
  assign rsp_o.mem_write   = rsp_q.mem_write;
  assign rsp_o.mem_data    = rsp_q.mem_data;

endmodule

`default_nettype wire

[hw/rtl/cartridge_bank_mapper_rtc_select_unit.sv]
`default_nettype none

// Cartridge bank mapper: translates each CPU bus beat (read or write, 16-bit address,
// data byte) into one cartridge memory beat for ROM, external RAM, a constant read value
// or no access, and tracks the ROM bank and RAM/RTC select written by the CPU. One beat
// is accepted every cycle while the result side keeps taking beats; each result passes
// through an input register, combinational translation logic and a result register.
// Backpressure on the result side stalls the input only once both registers are full.
// Configuration writes (ROM bank mask, external RAM size) take effect on the next edge
// and should be issued only while no beats are in flight.
module cartridge_bank_mapper_rtc_select_unit import cbm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  cbm_req_if.sink                  req_i,
  cbm_rsp_if.source                rsp_o
);

  cbm_cfg_t   cfg_q;
  cbm_stage_t stage;
  cbm_rsp_t   rsp_d;
  logic       out_free;
  logic       fire;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_bank_mask <= RomBankMaskRst;
      cfg_q.ram_size      <= RamSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRomBankMask: cfg_q.rom_bank_mask <= cfg_data_i[RomBankW-1:0];
        CfgRamSize:     cfg_q.ram_size      <= cfg_data_i[SizeW-1:0];
      endcase
    end
  end

  // Advance the held request when the result register has room
  assign fire = stage.valid && out_free;

  cbm_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (fire),
    .stage_o   (stage)
  );

  cbm_translate u_translate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .fire_i  (fire),
    .cfg_i   (cfg_q),
    .rsp_o   (rsp_d)
  );

  cbm_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rsp_i  (rsp_d),
    .load_i (fire),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

[dv/tb_cartridge_bank_mapper_rtc_select_unit.sv]
`default_nettype none

module tb_cartridge_bank_mapper_rtc_select_unit;
  import cbm_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned PhaseBeats  = 120;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned SettleWait  = 8;
  localparam int unsigned MaxReports  = 10;

  // One line of the directed stimulus: either a register setting or a bus beat
  typedef struct packed {
    logic                is_cfg;
    logic [RomBankW-1:0] mask;
    logic [SizeW-1:0]    size;
    cbm_req_t            beat;
    logic                typed;
    cbm_rsp_t            rsp;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  cbm_req_if req_if ();
  cbm_rsp_if rsp_if ();

  cartridge_bank_mapper_rtc_select_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Mirror of the mapper registers and bank state
  logic [RomBankW-1:0] cfg_mask;
  logic [SizeW-1:0]    cfg_size;
  logic [RomBankW-1:0] pred_rom_bank;
  logic [RamSelW-1:0]  pred_ram_sel;

  cbm_rsp_t    pending_maps[$];
  dir_row_t    dir_rows[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned settings_applied;
  logic        req_take;
  logic        rsp_take;
  cbm_rsp_t    rsp_seen;

  always #5 clk_i = ~clk_i;

  // Sample both channels on the falling edge ahead of the edge that acts on them
  always @(negedge clk_i) begin
    req_take = req_if.valid && req_if.ready;
    rsp_take = rsp_if.valid && rsp_if.ready;
    rsp_seen = '{rsp_if.target, rsp_if.mem_address, rsp_if.mem_write, rsp_if.mem_data};
  end

  // Translate one bus beat and advance the bank state
  function automatic cbm_rsp_t map_access(input cbm_req_t beat);
    cbm_rsp_t            r;
    logic [7:0]          page;
    logic [RomBankW-1:0] bank;
    int unsigned         win_pages;
    r = '0;
    page = beat.address[15:8];
    win_pages = ((cfg_size > RamWinBytes) ? RamWinBytes : int'(cfg_size)) / PageBytes;
    if (!beat.address[15]) begin
      if (beat.op == OpRead) begin
        if (!beat.address[14]) bank = '0;
        else if (pred_rom_bank == '0) bank = 7'd1;
        else bank = pred_rom_bank & cfg_mask;
        r.target      = TgtRom;
        r.mem_address = {bank, beat.address[13:0]};
      end else if (beat.address[15:13] == 3'b001) begin
        pred_rom_bank = beat.write_data[RomBankW-1:0];
      end else if (beat.address[15:13] == 3'b010 && beat.write_data <= RamSelMax) begin
        pred_ram_sel = beat.write_data[RamSelW-1:0];
      end
    end else if (beat.address[15:13] == 3'b101) begin
      if (pred_ram_sel >= RtcSelMin) begin
        if (beat.op == OpRead) begin
          r.target   = TgtConst;
          r.mem_data = RtcStubData;
        end
      end else if (int'(page[4:0]) < win_pages) begin
        r.target      = TgtRam;
        r.mem_address = MemAddrW'({pred_ram_sel[RamBankW-1:0], beat.address[12:0]});
        if (beat.op == OpWrite) begin
          r.mem_write = 1'b1;
          r.mem_data  = beat.write_data;
        end
      end else if (beat.op == OpRead) begin
        r.target   = TgtConst;
        r.mem_data = OpenBusData;
      end
    end
    return r;
  endfunction

  // Draw a beat, weighted toward the RAM window and the bank registers
  function automatic cbm_req_t rand_beat();
    cbm_req_t    b;
    int unsigned pick;
    b.op         = 1'($urandom_range(1, 0));
    b.write_data = 8'($urandom_range(255, 0));
    b.address    = 16'($urandom_range(16'hFFFF, 0));
    pick = $urandom_range(99);
    if (pick < 32) begin
      b.address = {3'b101, 13'($urandom)};
    end else if (pick < 52) begin
      b.op      = OpRead;
      b.address = {1'b0, 15'($urandom)};
    end else if (pick < 62) begin
      b.op      = OpWrite;
      b.address = {3'b001, 13'($urandom)};
      if ($urandom_range(7) == 0) b.write_data = {1'($urandom), 7'd0};
    end else if (pick < 74) begin
      b.op      = OpWrite;
      b.address = {3'b010, 13'($urandom)};
      if ($urandom_range(3) != 0) b.write_data = 8'($urandom_range(RamSelMax, 0));
    end
    return b;
  endfunction

  function automatic dir_row_t beat_row(input logic op, input logic [AddrW-1:0] addr,
                                        input logic [DataW-1:0] data);
    dir_row_t row;
    row = '0;
    row.beat = '{op, addr, data};
    return row;
  endfunction

  function automatic dir_row_t typed_row(input logic op, input logic [AddrW-1:0] addr,
                                         input logic [DataW-1:0] data,
                                         input cbm_target_e tgt,
                                         input logic [MemAddrW-1:0] maddr,
                                         input logic mwr, input logic [DataW-1:0] mdata);
    dir_row_t row;
    row = beat_row(op, addr, data);
    row.typed = 1'b1;
    row.rsp   = '{tgt, maddr, mwr, mdata};
    return row;
  endfunction

  // Offer one beat after a random gap and log its mapping once it is taken
  task automatic send_beat(input cbm_req_t beat, input logic typed, input cbm_rsp_t typed_rsp);
    cbm_rsp_t mapped;
    logic     taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= beat.op;
    req_if.address    <= beat.address;
    req_if.write_data <= beat.write_data;
    do begin
      @(negedge clk_i);
      taken = (req_if.ready === 1'b1);
      @(posedge clk_i);
    end while (!taken);
    mapped = map_access(beat);
    pending_maps.push_back(typed ? typed_rsp : mapped);
    beats_sent++;
  endtask

  // Drop valid and hold until every mapping has come back
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges
  task automatic apply_settings(input logic [RomBankW-1:0] mask, input logic [SizeW-1:0] size);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgRomBankMask;
    cfg_data <= CfgDataW'(mask);
    @(posedge clk_i);
    cfg_idx  <= CfgRamSize;
    cfg_data <= size;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cfg_mask = mask;
    cfg_size = size;
    settings_applied++;
  endtask

  // Result side: random or held-off ready, compare each beat with the oldest mapping
  always @(posedge clk_i) begin : rsp_check
    cbm_rsp_t got;
    cbm_rsp_t want;
    logic     bad;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_take) begin
        got = rsp_seen;
        if (pending_maps.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result beat: tgt=%0d addr=%06h wr=%0b data=%02h",
                     got.target, got.mem_address, got.mem_write, got.mem_data);
        end else begin
          want = pending_maps.pop_front();
          bad = (got.target !== want.target) || (got.mem_address !== want.mem_address) ||
                (got.mem_write !== want.mem_write) || (got.mem_data !== want.mem_data);
          if (bad) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch on result %0d: expected tgt=%0d addr=%06h wr=%0b data=%02h, %s",
                       results_checked, want.target, want.mem_address, want.mem_write,
                       want.mem_data,
                       $sformatf("got tgt=%0d addr=%06h wr=%0b data=%02h", got.target,
                                 got.mem_address, got.mem_write, got.mem_data));
          end
          results_checked++;
        end
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        rsp_if.ready <= 1'b0;
        hold_left = HoldCycles - 1;
        hold_done = 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_take || rsp_take) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("watchdog: no beat moved for %0d cycles, %0d mappings outstanding",
                   stall_cycles, pending_maps.size());
          $display("cartridge_bank_mapper_rtc_select_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    dir_row_t            row;
    logic [RomBankW-1:0] mask;
    logic [SizeW-1:0]    size;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OpRead;
    req_if.address    = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    req_take          = 1'b0;
    rsp_take          = 1'b0;
    rsp_seen          = '0;
    hold_req          = 1'b0;
    hold_done         = 1'b0;
    hold_left         = 0;
    stall_cycles      = 0;
    mismatches        = 0;
    beats_sent        = 0;
    results_checked   = 0;
    settings_applied  = 0;
    send_idle_pct     = 25;
    recv_idle_pct     = 49;
    cfg_mask          = RomBankMaskRst;
    cfg_size          = RamSizeRst;
    pred_rom_bank     = RomBankRst;
    pred_ram_sel      = RamSelRst;

    // Directed rows: reset state, region edges, bank zero, bad select, RTC mode, stubs
    dir_rows.push_back(typed_row(OpRead,  16'h0000, 8'h00, TgtRom,  21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'h3FFF, 8'hFF, TgtRom,  21'h003FFF, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'h4000, 8'h00, TgtRom,  21'h004000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hA000, 8'h00, TgtRam,  21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hBFFF, 8'h00, TgtRam,  21'h001FFF, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'hA123, 8'h5A, TgtRam,  21'h000123, 1'b1, 8'h5A));
    dir_rows.push_back(typed_row(OpWrite, 16'h2000, 8'h00, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'h4000, 8'h00, TgtRom,  21'h004000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h3FFF, 8'hFF, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'h7FFF, 8'h00, TgtRom,  21'h1FFFFF, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h2000, 8'h80, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'h5000, 8'h00, TgtRom,  21'h005000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h5FFF, 8'h07, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hA000, 8'h00, TgtRam,  21'h00E000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h4000, 8'h0D, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hB000, 8'h00, TgtRam,  21'h00F000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h4000, 8'h08, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hA000, 8'h00, TgtConst, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'hA000, 8'hFF, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h4000, 8'h0C, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hBFFF, 8'h00, TgtConst, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(beat_row(OpWrite, 16'h4000, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h0000, 8'hFF, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpWrite, 16'h6000, 8'h01, TgtNone, 21'h000000, 1'b0, 8'h00));
    dir_rows.push_back(typed_row(OpRead,  16'hFFFF, 8'h00, TgtNone, 21'h000000, 1'b0, 8'h00));
    // Shrink the RAM window to one page and narrow the ROM mask
    row = '0;
    row.is_cfg = 1'b1;
    row.mask   = 7'h03;
    row.size   = 16'd300;
    dir_rows.push_back(row);
    dir_rows.push_back(beat_row(OpRead,  16'hA0FF, 8'h00));
    dir_rows.push_back(beat_row(OpRead,  16'hA100, 8'h00));
    dir_rows.push_back(beat_row(OpWrite, 16'hBFFF, 8'hA5));
    dir_rows.push_back(beat_row(OpRead,  16'h4000, 8'h00));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drain();
        apply_settings(dir_rows[i].mask, dir_rows[i].size);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].rsp);
      end
    end

    // Random phases, each under its own register setting, with one idle pattern per pair of phases
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          mask = RomBankMaskRst;
          size = RamSizeRst;
        end
        1: begin
          mask = 7'h01;
          size = 16'd0;
        end
        2: begin
          mask = 7'h7F;
          size = 16'd32768;
        end
        3: begin
          mask = 7'((1 << $urandom_range(RomBankW, 1)) - 1);
          size = SizeW'($urandom_range(RamWinBytes / PageBytes, 0) * PageBytes);
        end
        4: begin
          mask = 7'($urandom_range(127, 1));
          size = 16'($urandom_range(32768, 0));
        end
        default: begin
          mask = 7'h03;
          size = SizeW'($urandom_range(RamWinBytes - 1, 1));
        end
      endcase
      wait_drain();
      apply_settings(mask, size);
      // Hold off the result side while beats keep coming, so the pipe fills
      if (ph == 4) hold_req = 1'b1;
      repeat (PhaseBeats) send_beat(rand_beat(), 1'b0, '0);
    end

    wait_drain();
    repeat (SettleWait) @(posedge clk_i);
    if (pending_maps.size() != 0) begin
      mismatches++;
      $display("%0d mappings never came back", pending_maps.size());
    end

    $display("covered %0d bus beats (%0d directed) under %0d register settings",
             beats_sent, dir_rows.size() - 1, settings_applied);
    $display("checked %0d result beats, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("cartridge_bank_mapper_rtc_select_unit test passed");
    end else begin
      $display("cartridge_bank_mapper_rtc_select_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
